### hdl/bba_pkg.sv
// Shared types, constants and command codes of the buddy block allocator.
package bba_pkg;

	localparam int REGION_ORDER = 10;
	localparam int ADDR_W       = REGION_ORDER;
	localparam int BYTES_W      = REGION_ORDER + 1;
	localparam logic [BYTES_W-1:0] REGION_BYTES = BYTES_W'(1) << REGION_ORDER;
	localparam logic [ADDR_W-1:0]  LAST_ADDR    = '1;
	localparam logic [4:0] TOP_ORD = 5'(REGION_ORDER);

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_QUOTA   = 2'd1,
		ST_NOFIT   = 2'd2,
		ST_BADFREE = 2'd3
	} status_t;

	typedef struct packed {
		logic        opcode;
		logic [15:0] request_size;
		logic [9:0]  release_offset;
	} req_t;

	typedef struct packed {
		logic [9:0]  block_offset;
		logic [1:0]  status;
		logic [10:0] bytes_in_use;
	} rsp_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_LOAD,
		CMD_READ_INC,
		CMD_RESTART,
		CMD_TAKE_EXACT,
		CMD_TAKE_SPLIT,
		CMD_NOFIT,
		CMD_QUOTA,
		CMD_SPLIT_WR,
		CMD_ALLOC_WR,
		CMD_READ,
		CMD_BADFREE,
		CMD_FREE_REL,
		CMD_READ_MATE,
		CMD_MERGE_ZERO
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic merge_wr;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free;
		logic clr_done;
		logic quota_fail;
		logic rvalid;
		logic last;
		logic exact;
		logic larger;
		logic free_ok;
		logic mate_ok;
		logic split_more;
		logic top;
		logic out_free;
	} dp_stat_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_CHK,
		S_SCAN1,
		S_SCAN2,
		S_SPLIT,
		S_COMMIT,
		S_FRD,
		S_FCHK,
		S_MRD,
		S_MCHK,
		S_MWR,
		S_OUT
	} state_t;

	// smallest order whose block holds size bytes; size 0 gives order 0
	function automatic logic [4:0] order_of(input logic [15:0] size);
		logic [4:0] k;
		k = 5'd16;
		for (int j = 16; j >= 0; j--) begin
			if ((17'(1) << j) >= {1'b0, size}) k = 5'(j);
		end
		return k;
	endfunction

endpackage

### hdl/buddy_block_allocator.sv
// Top level of the buddy block allocator: controller plus datapath.
// Buddy allocator over a 1024-byte region held as a 1024-entry block table in
// one single-port RAM. After reset a clearing pass over every entry sets up the
// table (one free block covering the region); no request is taken before it
// ends. Each request yields exactly one response. A free reads and checks the
// released entry, then in each merge step reads the buddy, clears one entry of
// the pair and writes the merged block; an allocate scans the table one entry
// a cycle through the single RAM port, first for an exact-order block, then
// for a larger block to split down. One request is in work at a time; the next
// one is taken while a finished response still waits in the output register.
module buddy_block_allocator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bba_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bba_pkg::rsp_t  rsp
);
	import bba_pkg::*;

	dp_cmd_t  ctl;
	dp_stat_t stat;

	// sequencing
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// table, counters, response register
	bba_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

### hdl/bba_ctrl.sv
// Sequencing state machine of the buddy block allocator.
module bba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  bba_pkg::dp_stat_t stat,
	output bba_pkg::dp_cmd_t  ctl
);
	import bba_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLR:    if (stat.clr_done) state_nx = S_IDLE;
			S_IDLE:   if (req_valid) state_nx = S_CHK;
			S_CHK: begin
				if (stat.is_free) state_nx = S_FRD;
				else if (stat.quota_fail) state_nx = S_OUT;
				else state_nx = S_SCAN1;
			end
			S_SCAN1: begin
				if (stat.rvalid && stat.exact) state_nx = S_COMMIT;
				else if (stat.rvalid && stat.last) state_nx = S_SCAN2;
			end
			S_SCAN2: begin
				if (stat.rvalid && stat.larger) state_nx = S_SPLIT;
				else if (stat.rvalid && stat.last) state_nx = S_OUT;
			end
			S_SPLIT:  if (!stat.split_more) state_nx = S_COMMIT;
			S_COMMIT: state_nx = S_OUT;
			S_FRD:    state_nx = S_FCHK;
			S_FCHK:   state_nx = stat.free_ok ? S_MRD : S_OUT;
			S_MRD:    state_nx = stat.top ? S_OUT : S_MCHK;
			S_MCHK:   state_nx = stat.mate_ok ? S_MWR : S_OUT;
			S_MWR:    state_nx = S_MRD;
			S_OUT:    if (stat.out_free) state_nx = S_IDLE;
			default:  state_nx = S_CLR;
		endcase
	end

	always_comb begin
		ctl = '{cmd: CMD_NONE, merge_wr: 1'b0, emit: 1'b0};
		req_ready = 1'b0;
		case (state_q)
			S_CLR: ctl.cmd = CMD_CLEAR;
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) ctl.cmd = CMD_LOAD;
			end
			S_CHK: begin
				if (!stat.is_free && stat.quota_fail) ctl.cmd = CMD_QUOTA;
			end
			S_SCAN1: begin
				if (stat.rvalid && stat.exact) ctl.cmd = CMD_TAKE_EXACT;
				else if (stat.rvalid && stat.last) ctl.cmd = CMD_RESTART;
				else ctl.cmd = CMD_READ_INC;
			end
			S_SCAN2: begin
				if (stat.rvalid && stat.larger) ctl.cmd = CMD_TAKE_SPLIT;
				else if (stat.rvalid && stat.last) ctl.cmd = CMD_NOFIT;
				else ctl.cmd = CMD_READ_INC;
			end
			S_SPLIT:  if (stat.split_more) ctl.cmd = CMD_SPLIT_WR;
			S_COMMIT: ctl.cmd = CMD_ALLOC_WR;
			S_FRD:    ctl.cmd = CMD_READ;
			S_FCHK:   ctl.cmd = stat.free_ok ? CMD_FREE_REL : CMD_BADFREE;
			S_MRD:    if (!stat.top) ctl.cmd = CMD_READ_MATE;
			S_MCHK:   if (stat.mate_ok) ctl.cmd = CMD_MERGE_ZERO;
			S_MWR:    ctl.merge_wr = 1'b1;
			S_OUT:    ctl.emit = stat.out_free;
			default:  ctl.cmd = CMD_NONE;
		endcase
	end

endmodule

### hdl/bba_dp.sv
// Datapath of the buddy block allocator: block table, counters and result register.
module bba_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::req_t     req,
	input  bba_pkg::dp_cmd_t  ctl,
	output bba_pkg::dp_stat_t stat,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bba_pkg::rsp_t     rsp
);
	import bba_pkg::*;

	// entry: [5] taken, [4:0] order+1 at a block start, 0 elsewhere
	logic [5:0]         mem [2**ADDR_W];
	logic [5:0]         rdata_s1;
	logic [ADDR_W-1:0]  raddr_s1;
	logic               rvalid_s1;
	logic [ADDR_W-1:0]  ptr_q, best_q, mate;
	logic [4:0]         k_q, ord_q;
	logic               free_q;
	logic [BYTES_W-1:0] total_q;
	logic [1:0]         st_q;
	logic               out_valid_q;
	rsp_t               out_q;
	logic               we, re;
	logic [ADDR_W-1:0]  waddr, raddr;
	logic [5:0]         wdata;
	logic [BYTES_W:0]   need;

	assign mate = ptr_q ^ (ADDR_W'(1) << ord_q);
	assign need = (BYTES_W+1)'(BYTES_W'(1) << k_q) + (BYTES_W+1)'(total_q);

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		waddr = ptr_q;
		raddr = ptr_q;
		wdata = '0;
		if (ctl.merge_wr) begin
			we = 1'b1;
			wdata = {1'b0, ord_q + 5'd2};
		end
		case (ctl.cmd)
			CMD_CLEAR: begin
				we = 1'b1;
				wdata = (ptr_q == '0) ? {1'b0, TOP_ORD + 5'd1} : 6'd0;
			end
			CMD_READ_INC, CMD_READ: re = 1'b1;
			CMD_READ_MATE: begin
				re = 1'b1;
				raddr = mate;
			end
			CMD_SPLIT_WR: begin
				we = 1'b1;
				waddr = best_q + (ADDR_W'(1) << (ord_q - 5'd1));
				wdata = {1'b0, ord_q};
			end
			CMD_ALLOC_WR: begin
				we = 1'b1;
				waddr = best_q;
				wdata = {1'b1, k_q + 5'd1};
			end
			CMD_FREE_REL: begin
				we = 1'b1;
				wdata = {1'b0, rdata_s1[4:0]};
			end
			CMD_MERGE_ZERO: begin
				we = 1'b1;
				waddr = (raddr_s1 < ptr_q) ? ptr_q : raddr_s1;
			end
			default: we = we;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			rvalid_s1 <= 1'b0;
			total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1 <= re;
			if (re) raddr_s1 <= raddr;
			if (ctl.merge_wr) ord_q <= ord_q + 5'd1;
			case (ctl.cmd)
				CMD_CLEAR:    ptr_q <= ptr_q + 1'b1;
				CMD_LOAD: begin
					free_q <= req.opcode;
					k_q <= order_of(req.request_size);
					ptr_q <= (req.opcode == OP_FREE) ? req.release_offset : '0;
					best_q <= '0;
					st_q <= ST_OK;
				end
				CMD_READ_INC: ptr_q <= ptr_q + 1'b1;
				CMD_RESTART:  ptr_q <= '0;
				CMD_TAKE_EXACT: best_q <= raddr_s1;
				CMD_TAKE_SPLIT: begin
					best_q <= raddr_s1;
					ord_q <= rdata_s1[4:0] - 5'd1;
				end
				CMD_NOFIT:    st_q <= ST_NOFIT;
				CMD_QUOTA:    st_q <= ST_QUOTA;
				CMD_SPLIT_WR: ord_q <= ord_q - 5'd1;
				CMD_ALLOC_WR: total_q <= total_q + (BYTES_W'(1) << k_q);
				CMD_BADFREE:  st_q <= ST_BADFREE;
				CMD_FREE_REL: begin
					ord_q <= rdata_s1[4:0] - 5'd1;
					total_q <= total_q - (BYTES_W'(1) << (rdata_s1[4:0] - 5'd1));
				end
				CMD_MERGE_ZERO: if (raddr_s1 < ptr_q) ptr_q <= raddr_s1;
				default: ptr_q <= ptr_q;
			endcase
			if (ctl.emit) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_q.block_offset <= (st_q == ST_OK) ? best_q : '0;
			out_q.status <= st_q;
			out_q.bytes_in_use <= total_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	always_comb begin
		stat.is_free    = free_q;
		stat.clr_done   = (ptr_q == LAST_ADDR);
		stat.quota_fail = (k_q > TOP_ORD) || (need > (BYTES_W+1)'(REGION_BYTES));
		stat.rvalid     = rvalid_s1;
		stat.last       = (raddr_s1 == LAST_ADDR);
		stat.exact      = (rdata_s1[4:0] == k_q + 5'd1) && !rdata_s1[5];
		stat.larger     = (rdata_s1[4:0] > k_q + 5'd1) && !rdata_s1[5];
		stat.free_ok    = (rdata_s1[4:0] != 5'd0) && rdata_s1[5];
		stat.mate_ok    = (rdata_s1[4:0] == ord_q + 5'd1) && !rdata_s1[5];
		stat.split_more = (ord_q > k_q);
		stat.top        = (ord_q >= TOP_ORD);
		stat.out_free   = !out_valid_q || rsp_ready;
	end

`ifndef SYNTHESIS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= REGION_BYTES) else $error("bytes in use beyond region");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_OK |-> out_q.block_offset == '0)
		else $error("offset not zero on failed request");
	a_split_order: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmd == CMD_SPLIT_WR |-> ord_q > k_q && ord_q <= TOP_ORD)
		else $error("split below requested order");
	a_alloc_quota: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cmd == CMD_ALLOC_WR |-> need <= (BYTES_W+1)'(REGION_BYTES))
		else $error("allocation beyond quota");
`endif

endmodule

### bench/testbench.sv
// Testbench of the buddy block allocator: directed and random requests against a predictor.
`timescale 1ns / 1ps

module testbench;
	import bba_pkg::*;

	localparam int REGION = 1 << REGION_ORDER;
	// no request is accepted for long stretches: during a table scan, plus the clear
	localparam int IDLE_LIMIT = 40000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	buddy_block_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	// predictor state: order+1 in bits 4..0 at a block start, taken flag in bit 5
	logic [5:0] blk_tab [REGION];
	int unsigned bytes_used;
	rsp_t expected_rsps[$];
	int errors;
	int idle_cycles;
	int unsigned live_offs[$]; // blocks the predictor holds as taken

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic int size_order(input logic [15:0] size);
		int k;
		k = 0;
		while (k < 17 && (32'd1 << k) < size) k++;
		return k;
	endfunction

	function automatic void table_reset();
		foreach (blk_tab[i]) blk_tab[i] = '0;
		blk_tab[0] = 6'(REGION_ORDER + 1);
		bytes_used = 0;
		live_offs.delete();
	endfunction

	// work out the response to one request and update the predicted table
	function automatic rsp_t predict_rsp(input req_t r);
		rsp_t o;
		int k, oo, off, mate, best;
		bit got;
		o = '0;
		best = 0;
		got = 0;
		if (r.opcode == OP_FREE) begin
			off = r.release_offset;
			if (blk_tab[off][4:0] == 0 || !blk_tab[off][5]) begin
				o.status = ST_BADFREE;
			end else begin
				oo = blk_tab[off][4:0] - 1;
				bytes_used -= (1 << oo);
				foreach (live_offs[i]) if (live_offs[i] == off) begin
					live_offs.delete(i);
					break;
				end
				blk_tab[off] = 6'(oo + 1);
				while (oo < REGION_ORDER) begin
					mate = (off ^ (1 << oo)) & (REGION - 1);
					if (blk_tab[mate][4:0] != oo + 1 || blk_tab[mate][5]) break;
					if (mate < off) begin
						blk_tab[off] = '0;
						off = mate;
					end else begin
						blk_tab[mate] = '0;
					end
					oo++;
					blk_tab[off] = 6'(oo + 1);
				end
				o.status = ST_OK;
			end
		end else begin
			k = size_order(r.request_size);
			if (k > REGION_ORDER || (1 << k) + bytes_used > REGION) begin
				o.status = ST_QUOTA;
			end else begin
				for (int i = 0; i < REGION; i++)
					if (!got && blk_tab[i][4:0] == k + 1 && !blk_tab[i][5]) begin
						best = i;
						got = 1;
					end
				for (int i = 0; i < REGION; i++)
					if (!got && blk_tab[i][4:0] > k + 1 && !blk_tab[i][5]) begin
						oo = blk_tab[i][4:0] - 1;
						while (oo > k) begin
							oo--;
							blk_tab[(i + (1 << oo)) & (REGION - 1)] = 6'(oo + 1);
						end
						best = i;
						got = 1;
					end
				if (!got) begin
					o.status = ST_NOFIT;
				end else begin
					blk_tab[best] = 6'(k + 1) | 6'h20;
					bytes_used += (1 << k);
					live_offs = {live_offs, best};
					o.status = ST_OK;
					o.block_offset = 10'(best);
				end
			end
		end
		o.bytes_in_use = 11'(bytes_used);
		return o;
	endfunction

	// short gaps mostly, the odd long one, often none
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// send one request; prediction is made at acceptance, in request order
	task automatic send_req(input logic op, input logic [15:0] size, input logic [9:0] off);
		req_t r;
		int g;
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		r.opcode = op;
		r.request_size = size;
		r.release_offset = off;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_rsps = {expected_rsps, predict_rsp(r)};
		@(negedge clk);
	endtask

	task automatic send_alloc(input logic [15:0] size);
		send_req(OP_ALLOC, size, 10'($urandom));
	endtask

	task automatic send_free(input logic [9:0] off);
		send_req(OP_FREE, 16'($urandom), off);
	endtask

	// response checker: sample at the rising edge
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				report($sformatf("unexpected response %p", rsp));
			end else begin
				rsp_t e;
				e = expected_rsps.pop_front();
				if (rsp.block_offset !== e.block_offset)
					report($sformatf("block_offset %0d, want %0d", rsp.block_offset,
						e.block_offset));
				if (rsp.status !== e.status)
					report($sformatf("status %0d, want %0d", rsp.status, e.status));
				if (rsp.bytes_in_use !== e.bytes_in_use)
					report($sformatf("bytes_in_use %0d, want %0d", rsp.bytes_in_use,
						e.bytes_in_use));
			end
		end
	end

	// receiver stalls, with long ready stretches too
	initial begin
		int g;
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(negedge clk);
			g = gap_len();
			if (g > 0) begin
				rsp_ready <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
	end

	// watchdog: cycles with nothing accepted on either channel
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// extremes of size: zero, one, powers and just past them, oversized
	task automatic test_sizes();
		send_alloc(16'd0);
		send_alloc(16'd1);
		send_alloc(16'd2);
		send_alloc(16'd3);
		send_alloc(16'd1024);        // quota, region partly used
		send_alloc(16'd1025);        // order above region
		send_alloc(16'hFFFF);
		send_alloc(16'h8000);
		send_free(10'd0);
		send_free(10'd1);
		send_free(10'd2);            // frees merge bytes 0..3, block at 4 stays taken
		send_alloc(16'd1024);        // whole region: quota, 4 bytes still in use
		send_free(10'd0);
	endtask

	// bad frees: not a start, not taken, double free
	task automatic test_bad_free();
		send_free(10'd0);            // free block at 0, not taken
		send_free(10'd1023);
		send_alloc(16'd100);
		send_free(10'd64);           // free block at 64, not taken
		send_free(10'd0);
		send_free(10'd0);            // double free
	endtask

	// fragmentation: no free block is large enough for the request
	task automatic test_fragment();
		for (int i = 0; i < 8; i++) send_alloc(16'd128);
		send_free(10'd0);
		send_free(10'd256);
		send_alloc(16'd200);         // 252 free bytes, largest block 128: quota
		send_free(10'd128);
		send_free(10'd384);
		for (int i = 4; i < 8; i++) send_free(10'(i * 128));
	endtask

	// random: mostly allocations and valid frees, some noise
	task automatic test_random(input int n);
		int p;
		logic [15:0] sz;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(0, 99);
			if (p < 45) begin
				case ($urandom_range(0, 3))
					0: sz = 16'($urandom_range(0, 16));
					1: sz = 16'($urandom_range(0, 128));
					2: sz = 16'($urandom_range(0, 1100));
					default: sz = 16'($urandom);
				endcase
				send_alloc(sz);
			end else if (p < 88 && live_offs.size() > 0) begin
				send_free(10'(live_offs[$urandom_range(0, live_offs.size() - 1)]));
			end else begin
				send_free(10'($urandom));
			end
		end
		// drain so later runs of the set can start from empty
		while (live_offs.size() > 0) send_free(10'(live_offs[0]));
	endtask

	initial begin
		int waited;
		errors = 0;
		idle_cycles = 0;
		table_reset();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		test_sizes();
		test_bad_free();
		test_fragment();
		test_random(540);
		req_valid <= 1'b0;

		waited = 0;
		while (expected_rsps.size() > 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
